/* rtl/ascon_permutation_unit_assert.svh */
// Assertion macros for the Ascon permutation unit.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef ASCON_PERMUTATION_UNIT_ASSERT_SVH
`define ASCON_PERMUTATION_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define APU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define APU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/apu_pkg.sv */
// Package for the Ascon permutation unit: state type, round constants and
// the single-round function. No dependencies.
package apu_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned WORDS    = 5;
    localparam int unsigned STATE_W  = WORD_W * WORDS;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned ROUNDS   = 12;
    localparam int unsigned IN_DATA_W  = 328;
    localparam int unsigned OUT_DATA_W = 320;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t             state_t [WORDS];
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam logic [7:0] ROUND_CONST [ROUNDS] = '{
        8'hF0, 8'hE1, 8'hD2, 8'hC3, 8'hB4, 8'hA5,
        8'h96, 8'h87, 8'h78, 8'h69, 8'h5A, 8'h4B
    };

    function automatic word_t rotr(input word_t v, input int unsigned k);
        rotr = (v >> k) | (v << (WORD_W - k));
    endfunction

    function automatic state_t ascon_round(input state_t s, input logic [7:0] rc);
        state_t w;
        state_t a;
        w = s;
        w[2] = w[2] ^ {{(WORD_W-8){1'b0}}, rc};
        w[0] = w[0] ^ w[4];
        w[4] = w[4] ^ w[3];
        w[2] = w[2] ^ w[1];
        a = w;
        w[0] = a[0] ^ (~a[1] & a[2]);
        w[1] = a[1] ^ (~a[2] & a[3]);
        w[2] = a[2] ^ (~a[3] & a[4]);
        w[3] = a[3] ^ (~a[4] & a[0]);
        w[4] = a[4] ^ (~a[0] & a[1]);
        w[1] = w[1] ^ w[0];
        w[0] = w[0] ^ w[4];
        w[3] = w[3] ^ w[2];
        w[2] = ~w[2];
        w[0] = w[0] ^ rotr(w[0], 19) ^ rotr(w[0], 28);
        w[1] = w[1] ^ rotr(w[1], 61) ^ rotr(w[1], 39);
        w[2] = w[2] ^ rotr(w[2], 1)  ^ rotr(w[2], 6);
        w[3] = w[3] ^ rotr(w[3], 10) ^ rotr(w[3], 17);
        w[4] = w[4] ^ rotr(w[4], 7)  ^ rotr(w[4], 41);
        ascon_round = w;
    endfunction

endpackage

/* rtl/ascon_permutation_unit.sv */
// Ascon-p permutation unit: twelve-stage pipeline, one round per stage.
// Depends on apu_pkg and ascon_permutation_unit_assert.svh.
//
//   channel | direction | tdata fields (low bit up)
//   s_axis  | in        | in_word_0..in_word_4 (64 each), round_count (4), 4 zero bits
//   m_axis  | out       | out_word_0..out_word_4 (64 each)
//
// An input beat passes through the twelve round stage registers to the output
// beat; a new beat is taken every cycle while the output is drained.
// Stage k runs round k only when the saturated count is at least 12 - k, otherwise
// passes the state through. Reset clears all stage valid bits.
// An output stall freezes the whole pipeline, bubbles included.
module ascon_permutation_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // in_word_0, in_word_1, in_word_2, in_word_3, in_word_4, round_count, pad
    input  logic [apu_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_word_0, out_word_1, out_word_2, out_word_3, out_word_4
    output logic [apu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import apu_pkg::*;

    `include "ascon_permutation_unit_assert.svh"

    logic                valid_reg [ROUNDS];
    cnt_t                cnt_reg   [ROUNDS];
    state_t              state_reg [ROUNDS];
    state_t              state_next [ROUNDS];
    state_t              in_state;
    cnt_t                in_cnt;
    logic                adv;

    assign adv           = !valid_reg[ROUNDS-1] || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        for (int i = 0; i < WORDS; i++)
        begin
            in_state[i] = s_axis_tdata[i*WORD_W +: WORD_W];
        end
        if (s_axis_tdata[STATE_W +: CNT_W] > CNT_W'(ROUNDS))
        begin
            in_cnt = CNT_W'(ROUNDS);
        end
        else
        begin
            in_cnt = s_axis_tdata[STATE_W +: CNT_W];
        end
    end

    for (genvar k = 0; k < ROUNDS; k++)
    begin : g_stage
        state_t stage_in;
        cnt_t   stage_cnt;
        logic   stage_valid;

        if (k == 0)
        begin : g_first
            assign stage_in    = in_state;
            assign stage_cnt   = in_cnt;
            assign stage_valid = s_axis_tvalid;
        end
        else
        begin : g_rest
            assign stage_in    = state_reg[k-1];
            assign stage_cnt   = cnt_reg[k-1];
            assign stage_valid = valid_reg[k-1];
        end

        always_comb
        begin
            if (stage_cnt >= CNT_W'(ROUNDS - k))
            begin
                state_next[k] = ascon_round(stage_in, ROUND_CONST[k]);
            end
            else
            begin
                state_next[k] = stage_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= stage_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                state_reg[k] <= state_next[k];
                cnt_reg[k]   <= stage_cnt;
            end
        end
    end

    assign m_axis_tvalid = valid_reg[ROUNDS-1];

    always_comb
    begin
        for (int i = 0; i < WORDS; i++)
        begin
            m_axis_tdata[i*WORD_W +: WORD_W] = state_reg[ROUNDS-1][i];
        end
    end

    `APU_ASSERT_NEXT(a_accept_loads, s_axis_tvalid && s_axis_tready,
        valid_reg[0] && cnt_reg[0] == $past(in_cnt), "accepted beat not in stage 0")
    `APU_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `APU_ASSERT_NEXT(a_no_loss, adv && valid_reg[ROUNDS-2],
        m_axis_tvalid, "beat dropped entering the last stage")
    `APU_ASSERT_SAME(a_cnt_sat, valid_reg[0],
        cnt_reg[0] <= CNT_W'(ROUNDS), "round count not saturated")

endmodule
